[sv/cbd_pkg.sv]
// Package with the phase and status types, framing characters and helpers of the chunked decoder.
`timescale 1ns / 1ps

package cbd_pkg;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_SIZE_LF = 3'd1,
    PH_DATA    = 3'd2,
    PH_DATA_CR = 3'd3,
    PH_DATA_LF = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2,
    ST_BIG  = 2'd3
  } status_e;

  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_BODY_SIZE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHUNKED_ENABLE = 1'd1;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  // Decodes one ASCII hex digit of either case.
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.ok    = 1'b0;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok    = 1'b1;
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.ok    = 1'b1;
      r.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.ok    = 1'b1;
      r.value = 4'(c - 8'h37);
    end
    return r;
  endfunction

endpackage

[sv/cbd_if.sv]
// Stream interfaces for raw body bytes and decoded results.
`timescale 1ns / 1ps

interface cbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       starts_body;

  modport source (output valid, output body_byte, output starts_body, input ready);
  modport sink (input valid, input body_byte, input starts_body, output ready);
endinterface

interface cbd_result_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [1:0] status;

  modport source (output valid, output payload_valid, output payload_byte, output status,
                  input ready);
  modport sink (input valid, input payload_valid, input payload_byte, input status,
                output ready);
endinterface

[sv/chunked_body_decoder.sv]
// Top level of the HTTP chunked body decoder with its result register.
`timescale 1ns / 1ps

// The decoder takes one raw body byte per clock and gives one result per byte: a decoded
// payload byte when there is one and the sticky body status. Each byte is decoded in the
// cycle of its transfer and its result appears in the result register on the next cycle,
// so the block sustains one byte per clock; the input is stalled only while a result waits
// in the result register and the output side is not ready. The user must write
// configuration via the write port only while no transfer is in flight; not enforced.
module chunked_body_decoder
  import cbd_pkg::*;
#(
  parameter int unsigned SIZE_BITS  = 32,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  cbd_byte_if.sink               in_ch,
  cbd_result_if.source           out_ch,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned CMP_W = (COUNT_BITS > CFG_DATA_W) ? COUNT_BITS : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] max_q;
  logic                  en_q;

  phase_e                phase_q, phase_d;
  logic [SIZE_BITS-1:0]  rem_q, rem_d;
  logic                  seen_q, seen_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  status_e               st_q, st_d;

  logic                  res_valid_q;
  logic                  res_pv_q, res_pv_d;
  logic [7:0]            res_byte_q, res_byte_d;
  logic [1:0]            res_st_q;

  logic                  accept;
  logic                  busy_in;
  logic                  too_big;
  phase_e                phase_in;
  hex_digit_t            hex;

  assign in_ch.ready = !res_valid_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign hex         = hex_decode(in_ch.body_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_MAX_BODY_SIZE) begin
        max_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_CHUNKED_ENABLE) begin
        en_q <= cfg_data_i[0];
      end
    end
  end

  // The state seen by this byte, after a new body has cleared it.
  always_comb begin
    logic [COUNT_BITS-1:0] cnt_base;
    cnt_base = in_ch.starts_body ? '0 : cnt_q;
    busy_in  = in_ch.starts_body || (st_q == ST_BUSY);
    phase_in = in_ch.starts_body ? PH_SIZE : phase_q;
    if (cnt_base != '1) begin
      cnt_d = cnt_base + COUNT_BITS'(1);
    end else begin
      cnt_d = cnt_base;
    end
    too_big = (max_q != '0) && (CMP_W'(cnt_d) > CMP_W'(max_q));
  end

  always_comb begin
    phase_d = phase_in;
    rem_d   = in_ch.starts_body ? '0 : rem_q;
    seen_d  = in_ch.starts_body ? 1'b0 : seen_q;
    st_d    = in_ch.starts_body ? ST_BUSY : st_q;
    if (busy_in) begin
      if (too_big) begin
        st_d = ST_BIG;
      end else if (en_q) begin
        unique case (phase_in)
          PH_SIZE: begin
            if (hex.ok) begin
              if (rem_d[SIZE_BITS-1 -: 4] != 4'd0) begin
                st_d = ST_BAD;
              end else begin
                rem_d  = {rem_d[SIZE_BITS-5:0], hex.value};
                seen_d = 1'b1;
              end
            end else if (in_ch.body_byte == CHAR_CR && seen_d) begin
              phase_d = PH_SIZE_LF;
            end else begin
              st_d = ST_BAD;
            end
          end
          PH_SIZE_LF: begin
            if (in_ch.body_byte != CHAR_LF) begin
              st_d = ST_BAD;
            end else if (rem_d == '0) begin
              phase_d = PH_DONE;
              st_d    = ST_DONE;
            end else begin
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            if (rem_d != '0) begin
              rem_d = rem_d - SIZE_BITS'(1);
            end
            if (rem_d == '0) begin
              phase_d = PH_DATA_CR;
            end
          end
          PH_DATA_CR: begin
            if (in_ch.body_byte == CHAR_CR) begin
              phase_d = PH_DATA_LF;
            end else begin
              st_d = ST_BAD;
            end
          end
          PH_DATA_LF: begin
            if (in_ch.body_byte == CHAR_LF) begin
              phase_d = PH_SIZE;
              rem_d   = '0;
              seen_d  = 1'b0;
            end else begin
              st_d = ST_BAD;
            end
          end
          default: begin
            st_d = ST_DONE;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_pv_d   = busy_in && !too_big && (!en_q || phase_in == PH_DATA);
    res_byte_d = res_pv_d ? in_ch.body_byte : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIZE;
      rem_q       <= '0;
      seen_q      <= 1'b0;
      cnt_q       <= '0;
      st_q        <= ST_BUSY;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        rem_q       <= rem_d;
        seen_q      <= seen_d;
        st_q        <= st_d;
        res_valid_q <= 1'b1;
        if (busy_in) begin
          cnt_q <= cnt_d;
        end else begin
          cnt_q <= in_ch.starts_body ? '0 : cnt_q;
        end
      end else if (out_ch.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_pv_q   <= res_pv_d;
      res_byte_q <= res_byte_d;
      res_st_q   <= st_d;
    end
  end

  assign out_ch.valid         = res_valid_q;
  assign out_ch.payload_valid = res_pv_q;
  assign out_ch.payload_byte  = res_byte_q;
  assign out_ch.status        = res_st_q;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the chunked body decoder: framing, limits, pass-through, random bodies.
`timescale 1ns / 1ps

module testbench;
  import cbd_pkg::*;

  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] LOWER_A    = 8'h61;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    status_e    status;
  } decoded_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_we_i    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;

  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_starts = 1'b0;
  logic       out_ready = 1'b0;

  bit          calm = 1'b0;
  int unsigned sent_count = 0;
  int unsigned errors = 0;

  logic [31:0] cfg_max_body = 32'd0;
  logic        cfg_chunked  = 1'b1;

  phase_e      dec_phase      = PH_SIZE;
  logic [31:0] dec_remaining  = 32'd0;
  logic        dec_digit_seen = 1'b0;
  logic [31:0] dec_count      = 32'd0;
  status_e     dec_status     = ST_BUSY;

  decoded_t   pending_results[$];
  logic [7:0] frame_q[$];

  cbd_byte_if   in_if ();
  cbd_result_if out_if ();

  assign in_if.valid       = in_valid;
  assign in_if.body_byte   = in_byte;
  assign in_if.starts_body = in_starts;
  assign out_if.ready      = out_ready;

  chunked_body_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void decode_byte(input logic [7:0] c, input logic fresh,
                                      output decoded_t r);
    logic       is_hex;
    logic [3:0] nib;
    is_hex = 1'b0;
    nib = 4'd0;
    r.payload_valid = 1'b0;
    r.payload_byte = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      is_hex = 1'b1;
      nib = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      is_hex = 1'b1;
      nib = c[3:0] + 4'd9;
    end
    if (fresh) begin
      dec_phase = PH_SIZE;
      dec_remaining = 32'd0;
      dec_digit_seen = 1'b0;
      dec_count = 32'd0;
      dec_status = ST_BUSY;
    end
    if (dec_status == ST_BUSY) begin
      if (dec_count != 32'hFFFF_FFFF) dec_count = dec_count + 32'd1;
      if (cfg_max_body != 32'd0 && dec_count > cfg_max_body) begin
        dec_status = ST_BIG;
      end else if (!cfg_chunked) begin
        r.payload_valid = 1'b1;
        r.payload_byte = c;
      end else begin
        case (dec_phase)
          PH_SIZE: begin
            if (is_hex) begin
              if (dec_remaining[31:28] != 4'd0) begin
                dec_status = ST_BAD;
              end else begin
                dec_remaining = {dec_remaining[27:0], nib};
                dec_digit_seen = 1'b1;
              end
            end else if (c == CHAR_CR && dec_digit_seen) begin
              dec_phase = PH_SIZE_LF;
            end else begin
              dec_status = ST_BAD;
            end
          end
          PH_SIZE_LF: begin
            if (c != CHAR_LF) begin
              dec_status = ST_BAD;
            end else if (dec_remaining == 32'd0) begin
              dec_phase = PH_DONE;
              dec_status = ST_DONE;
            end else begin
              dec_phase = PH_DATA;
            end
          end
          PH_DATA: begin
            r.payload_valid = 1'b1;
            r.payload_byte = c;
            if (dec_remaining != 32'd0) dec_remaining = dec_remaining - 32'd1;
            if (dec_remaining == 32'd0) dec_phase = PH_DATA_CR;
          end
          PH_DATA_CR: begin
            if (c == CHAR_CR) dec_phase = PH_DATA_LF;
            else dec_status = ST_BAD;
          end
          PH_DATA_LF: begin
            if (c == CHAR_LF) begin
              dec_phase = PH_SIZE;
              dec_remaining = 32'd0;
              dec_digit_seen = 1'b0;
            end else begin
              dec_status = ST_BAD;
            end
          end
          default: begin
            dec_status = ST_DONE;
          end
        endcase
      end
    end
    r.status = dec_status;
  endfunction

  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= 33);
  end

  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.payload_valid !== want.payload_valid) begin
          $error("payload_valid: expected %0d, got %0d", want.payload_valid,
                 out_if.payload_valid);
          errors++;
        end
        if (out_if.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte, out_if.payload_byte);
          errors++;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          errors++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fresh);
    decoded_t r;
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_starts <= fresh;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    decode_byte(b, fresh, r);
    pending_results = {pending_results, r};
    sent_count++;
  endtask

  task automatic send_text(input string s, input logic fresh);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fresh && i == 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MAX_BODY_SIZE) cfg_max_body = value;
    else cfg_chunked = value[0];
  endtask

  task automatic add_frame_byte(input logic [7:0] b);
    frame_q = {frame_q, b};
  endtask

  task automatic push_nibble(input logic [3:0] n);
    if (n < 4'd10) add_frame_byte(DIGIT_ZERO + 8'(n));
    else add_frame_byte(($urandom_range(1) ? UPPER_A : LOWER_A) + 8'(n) - 8'd10);
  endtask

  task automatic push_size(input logic [31:0] value, input int digits);
    for (int i = digits - 1; i >= 0; i--) push_nibble(value[4*i +: 4]);
    add_frame_byte(CHAR_CR);
    add_frame_byte(CHAR_LF);
  endtask

  // Mostly well-formed bodies; some get a byte overwritten or dropped, and some
  // open with a huge or overflowing size and are cut short by the next body.
  task automatic build_body();
    int unsigned mode;
    int unsigned len;
    logic [31:0] big;
    frame_q.delete();
    mode = $urandom_range(9);
    if (mode == 9) begin
      big = $urandom;
      if ($urandom_range(1)) push_nibble(4'($urandom_range(1, 15)));
      push_size(big, 8);
      repeat ($urandom_range(1, 4)) add_frame_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(3)) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
        push_size(len, ((len > 15) ? 2 : 1) + $urandom_range(2));
        repeat (len) add_frame_byte(8'($urandom));
        add_frame_byte(CHAR_CR);
        add_frame_byte(CHAR_LF);
      end
      push_size(32'd0, 1 + $urandom_range(1));
      if ($urandom_range(3) == 0) add_frame_byte(8'($urandom));
      if (mode == 6 || mode == 7) frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom);
      else if (mode == 8) frame_q.delete($urandom_range(frame_q.size() - 1));
    end
  endtask

  task automatic run_random(input int unsigned goal);
    int unsigned first;
    first = sent_count;
    while (sent_count - first < goal) begin
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), $urandom_range(2) == 0);
      end else begin
        build_body();
        foreach (frame_q[i]) send_byte(frame_q[i], i == 0);
      end
    end
  endtask

  task automatic test_good_body();
    write_reg(REG_MAX_BODY_SIZE, 32'd0);
    write_reg(REG_CHUNKED_ENABLE, 32'd1);
    send_text("1\015\012A\015\0120\015\012Z", 1'b1);
  endtask

  task automatic test_framing_errors();
    send_text("g", 1'b1);
    send_text("\015", 1'b1);
    send_text("fFfFfFfF0", 1'b1);
    send_text("1\015X", 1'b1);
  endtask

  task automatic test_size_limit();
    write_reg(REG_MAX_BODY_SIZE, 32'd3);
    send_text("1\015\012A", 1'b1);
  endtask

  // Toggling the enable within a body keeps the held phase.
  task automatic test_pass_through();
    write_reg(REG_MAX_BODY_SIZE, 32'hFFFF_FFFF);
    write_reg(REG_CHUNKED_ENABLE, 32'd0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    write_reg(REG_CHUNKED_ENABLE, 32'd1);
    send_text("1\015", 1'b0);
    write_reg(REG_CHUNKED_ENABLE, 32'd0);
    send_text("q", 1'b0);
    write_reg(REG_CHUNKED_ENABLE, 32'd1);
    send_text("\012w\015\012", 1'b0);
  endtask

  task automatic test_random_unlimited();
    write_reg(REG_MAX_BODY_SIZE, 32'd0);
    run_random(120);
    calm = 1'b1;
    run_random(80);
    calm = 1'b0;
    run_random(60);
  endtask

  task automatic test_random_limited();
    write_reg(REG_MAX_BODY_SIZE, 32'($urandom_range(8, 40)));
    run_random(100);
    write_reg(REG_MAX_BODY_SIZE, 32'd1);
    run_random(20);
  endtask

  task automatic test_random_pass_through();
    write_reg(REG_MAX_BODY_SIZE, 32'hFFFF_FFFF);
    write_reg(REG_CHUNKED_ENABLE, 32'd0);
    run_random(40);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_good_body();
    test_framing_errors();
    test_size_limit();
    test_pass_through();
    test_random_unlimited();
    test_random_limited();
    test_random_pass_through();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("status: fail");
    $finish;
  end

endmodule
